// ===== rtl/core/stld_pkg.sv =====
// Shared constant and controller-to-datapath command type of the tone detector.
package stld_pkg;

	localparam int unsigned POST_SHIFT = 11;

	typedef struct packed {
		logic in_load;
		logic acc_en;
		logic finish;
		logic sq_sel;
		logic sq_i_load;
		logic sq_q_load;
		logic out_load;
	} stld_cmd_t;

endpackage

// ===== rtl/core/stld_dp.sv =====
// Datapath of the tone detector: correlation products, accumulators, shared squarer and power register.
module stld_dp
	import stld_pkg::*;
#(
	parameter int unsigned SAMPLE_WIDTH = 16,
	parameter int unsigned ACC_W = 42
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  stld_cmd_t                                   cmd,
	input  logic signed [SAMPLE_WIDTH-1:0]              sample,
	input  logic signed [SAMPLE_WIDTH-1:0]              cos_ref,
	input  logic signed [SAMPLE_WIDTH-1:0]              sin_ref,
	output logic        [2*(ACC_W-POST_SHIFT)-1:0]      power
);

	localparam int unsigned PROD_W = 2 * SAMPLE_WIDTH;
	localparam int unsigned EXT_W = ACC_W - PROD_W;
	localparam int unsigned SH_W = ACC_W - POST_SHIFT;
	localparam int unsigned POW_W = 2 * SH_W;

	logic signed [PROD_W-1:0] prod_i_s1;
	logic signed [PROD_W-1:0] prod_q_s1;
	logic signed [ACC_W-1:0]  acc_i_q;
	logic signed [ACC_W-1:0]  acc_q_q;
	logic signed [ACC_W-1:0]  sum_i;
	logic signed [ACC_W-1:0]  sum_q;
	logic signed [SH_W-1:0]   sh_i_q;
	logic signed [SH_W-1:0]   sh_q_q;
	logic signed [SH_W-1:0]   sq_op;
	logic signed [POW_W-1:0]  sq_prod;
	logic        [POW_W-1:0]  sq_i_q;
	logic        [POW_W-1:0]  sq_q_q;
	logic        [POW_W-1:0]  power_q;

	assign sum_i = acc_i_q + signed'({{EXT_W{prod_i_s1[PROD_W-1]}}, prod_i_s1});
	assign sum_q = acc_q_q + signed'({{EXT_W{prod_q_s1[PROD_W-1]}}, prod_q_s1});

	assign sq_op = cmd.sq_sel ? sh_q_q : sh_i_q;
	assign sq_prod = sq_op * sq_op;

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			prod_i_s1 <= sample * cos_ref;
			prod_q_s1 <= sample * sin_ref;
		end
		if (cmd.sq_i_load) begin
			sq_i_q <= sq_prod;
		end
		if (cmd.sq_q_load) begin
			sq_q_q <= sq_prod;
		end
		if (cmd.out_load) begin
			power_q <= sq_i_q + sq_q_q;
		end
		if (cmd.finish) begin
			sh_i_q <= sum_i[ACC_W-1:POST_SHIFT];
			sh_q_q <= sum_q[ACC_W-1:POST_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (cmd.finish) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (cmd.acc_en) begin
			acc_i_q <= sum_i;
			acc_q_q <= sum_q;
		end
	end

	assign power = power_q;

endmodule

// ===== rtl/core/stld_ctrl.sv =====
// Controller state machine of the tone detector: handshakes and sequencing of the symbol close.
module stld_ctrl
	import stld_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      last_sample,
	output logic      out_valid,
	input  logic      out_ready,
	output stld_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_RUN,
		S_FIN,
		S_SQ_I,
		S_SQ_Q,
		S_SUM
	} state_t;

	state_t state_q;
	logic   acc_en_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == S_RUN);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.in_load = accept;
		cmd.acc_en = acc_en_q;
		case (state_q)
			S_FIN: begin
				cmd.finish = 1'b1;
			end
			S_SQ_I: begin
				cmd.sq_i_load = 1'b1;
			end
			S_SQ_Q: begin
				cmd.sq_sel = 1'b1;
				cmd.sq_q_load = 1'b1;
			end
			S_SUM: begin
				cmd.out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			acc_en_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_en_q <= accept;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_RUN: begin
					if (accept && last_sample) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_SQ_I;
				end
				S_SQ_I: begin
					state_q <= S_SQ_Q;
				end
				S_SQ_Q: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (out_free) begin
						state_q <= S_RUN;
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// The closing request's product must be waiting when the symbol is closed.
	a_fin_has_product: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> acc_en_q)
		else $error("symbol closed without its last product");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("power register loaded over an untaken result");

	// Sequencing steps never overlap.
	a_steps_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.finish, cmd.sq_i_load, cmd.sq_q_load, cmd.out_load}))
		else $error("overlapping datapath steps");

	// No new request is taken while a symbol is being closed.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_sample) |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("request accepted while closing a symbol");

endmodule

// ===== rtl/core/square_law_tone_detector.sv =====
// Top level of the square-law tone detector: controller and datapath.
//
// Each request carries one sample with its cosine and sine references and is multiplied and
// accumulated at one request per clock cycle while no symbol is being closed; the input
// multipliers and the accumulator adders set that figure. The request flagged last of a symbol
// is followed by a close in which input is held off: the final accumulation with the 11-bit
// arithmetic shift, two squarings on a single shared squarer, and the sum into the output
// register. The close stalls in its last step only when the previous power result has not yet
// been taken. Accumulators are 2*SAMPLE_WIDTH + clog2(MAX_SYMBOL_LEN) bits wide and wrap beyond
// that symbol length; the power result is exact for the shifted wrapped values.
module square_law_tone_detector
	import stld_pkg::*;
#(
	parameter int unsigned MAX_SYMBOL_LEN = 1024,
	parameter int unsigned SAMPLE_WIDTH = 16,
	localparam int unsigned ACC_W = 2 * SAMPLE_WIDTH + $clog2(MAX_SYMBOL_LEN),
	localparam int unsigned POW_W = 2 * (ACC_W - POST_SHIFT)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] cos_ref,
	input  logic signed [SAMPLE_WIDTH-1:0] sin_ref,
	input  logic                           last_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic        [POW_W-1:0]        power
);

	stld_cmd_t cmd;

	stld_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_sample(last_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd        (cmd)
	);

	stld_dp #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.ACC_W       (ACC_W)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.cos_ref(cos_ref),
		.sin_ref(sin_ref),
		.power  (power)
	);

endmodule
